[hw/rtl/thdns_pkg.sv]
// Shared types and defaults for the text hex/decimal number swapper.
// Holds the controller command and datapath status structs; no dependencies.
package thdns_pkg;

  // Default number formats
  localparam int HEX_DIGITS_DFLT = 8;
  localparam int VALUE_BITS_DFLT = 31;

  // Commands from the controller, at most one high in a cycle
  typedef struct packed {
    logic accept;   // take the input byte, resolve a held zero
    logic main;     // classify the byte against the scan state
    logic conv;     // one shift-add-3 step of the decimal converter
    logic num;      // emit or skip one character of a number
    logic chr;      // emit the held text byte
    logic flush;    // end of line: start the final number, clear state
  } cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic acc_done;   // held zero met 'x': byte fully handled
    logic acc_hex;    // ... and a decimal run must be printed in hex first
    logic acc_flush;  // ... and the byte ends the line
    logic main_num;   // main step starts a number printout
    logic main_hex;   // that printout is hex
    logic eol;        // current byte ends the line
    logic conv_done;  // last converter step
    logic num_done;   // last character position of the number
    logic char_pend;  // text byte waits behind the number
    logic flush_due;  // end of line not yet flushed
    logic flush_num;  // flush prints a number
    logic flush_hex;  // that number is hex
    logic out_free;   // output register can take a byte this cycle
  } stat_t;

endpackage

[hw/rtl/thdns_ctrl.sv]
// Sequencing controller for the number swapper.
// Depends on thdns_pkg (cmd_t, stat_t); drives the datapath by commands only.
module thdns_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  thdns_pkg::stat_t   stat_i,
  output thdns_pkg::cmd_t    cmd_o
);
  import thdns_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MAIN  = 6'b000010,
    ST_CONV  = 6'b000100,
    ST_NUM   = 6'b001000,
    ST_CHAR  = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.acc_hex) begin
            state_d = ST_NUM;
          end else if (stat_i.acc_done) begin
            state_d = stat_i.acc_flush ? ST_FLUSH : ST_IDLE;
          end else begin
            state_d = ST_MAIN;
          end
        end
      end
      ST_MAIN: begin
        // waits for a free output, as a text byte may go out directly
        if (stat_i.out_free) begin
          cmd_o.main = 1'b1;
          if (stat_i.main_num) begin
            state_d = stat_i.main_hex ? ST_NUM : ST_CONV;
          end else begin
            state_d = stat_i.eol ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (stat_i.conv_done) begin
          state_d = ST_NUM;
        end
      end
      ST_NUM: begin
        if (stat_i.out_free) begin
          cmd_o.num = 1'b1;
          if (stat_i.num_done) begin
            if (stat_i.char_pend) begin
              state_d = ST_CHAR;
            end else if (stat_i.flush_due) begin
              state_d = ST_FLUSH;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_CHAR: begin
        if (stat_i.out_free) begin
          cmd_o.chr = 1'b1;
          state_d   = stat_i.flush_due ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (stat_i.flush_num) begin
          state_d = stat_i.flush_hex ? ST_NUM : ST_CONV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/thdns_dpath.sv]
// Datapath of the number swapper: scan state, accumulator, hex/decimal printer
// and output register. Depends on thdns_pkg; driven by thdns_ctrl commands.
module thdns_dpath #(
  parameter int HEX_DIGITS = thdns_pkg::HEX_DIGITS_DFLT,
  parameter int VALUE_BITS = thdns_pkg::VALUE_BITS_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         char_in_i,
  input  logic               end_of_line_i,
  input  thdns_pkg::cmd_t    cmd_i,
  output thdns_pkg::stat_t   stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         char_out_o,
  output logic               last_of_run_o
);
  import thdns_pkg::*;

  localparam int MAX_RESULTS = 12;
  localparam int HEX_W       = 4 * HEX_DIGITS;
  localparam int DEC_DIGITS  = (VALUE_BITS * 301) / 1000 + 1;
  localparam int DEC_W       = 4 * DEC_DIGITS;
  localparam int MAX_DIG     = (HEX_DIGITS > DEC_DIGITS) ? HEX_DIGITS : DEC_DIGITS;
  localparam int IDX_W       = $clog2(MAX_DIG);
  localparam int HEX_IDX_W   = $clog2(HEX_DIGITS);
  localparam int DEC_IDX_W   = $clog2(DEC_DIGITS);
  localparam int CONV_W      = $clog2(VALUE_BITS);
  localparam int ACC_W       = VALUE_BITS + 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CHR_0 = 8'h30;
  localparam logic [7:0] CHR_9 = 8'h39;
  localparam logic [7:0] CHR_A = 8'h41;
  localparam logic [7:0] CHR_F = 8'h46;
  localparam logic [7:0] CHR_X = 8'h78;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_X    = 2'd1,
    PFX_ZERO = 2'd2
  } pfx_e;

  // Scan state and current byte
  mode_e                 mode_q, mode_d;
  logic                  zp_q, zp_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [7:0]            char_q, char_d;
  logic                  eol_q, eol_d;
  logic                  char_pend_q, char_pend_d;
  logic                  flushed_q, flushed_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Number printer
  logic [VALUE_BITS-1:0]       num_q, num_d;
  logic                        hex_q, hex_d;
  pfx_e                        pfx_q, pfx_d;
  logic [IDX_W-1:0]            idx_q, idx_d;
  logic                        started_q, started_d;
  logic [DEC_DIGITS-1:0][3:0]  bcd_q, bcd_d;
  logic [CONV_W-1:0]           conv_cnt_q, conv_cnt_d;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       out_last_q;

  logic                        is_zero, is_dec, is_hex, in_is_x;
  logic [3:0]                  dig_val;
  logic [VALUE_BITS-1:0]       digit_ext;
  logic                        acc_b16;
  logic [3:0]                  acc_d;
  logic [ACC_W-1:0]            acc_ext, acc_prod, acc_sum;
  logic [VALUE_BITS-1:0]       acc_res;
  logic                        flush_look;
  logic [HEX_DIGITS-1:0][3:0]  hex_nib;
  logic [DEC_DIGITS-1:0][3:0]  bcd_adj;
  logic [DEC_W-1:0]            adj_flat;
  logic [3:0]                  cur_dig;
  logic [7:0]                  dig_chr;
  logic                        ld_hex, ld_dec;
  logic [VALUE_BITS-1:0]       ld_val;
  logic                        emit_req, emit_last, emit_en, out_free;
  logic [7:0]                  emit_chr;

  // Byte classes
  assign is_zero   = (char_q == CHR_0);
  assign is_dec    = (char_q >= CHR_0) && (char_q <= CHR_9);
  assign is_hex    = is_dec || ((char_q >= CHR_A) && (char_q <= CHR_F));
  assign dig_val   = is_dec ? char_q[3:0] : (char_q[3:0] + 4'd9);
  assign digit_ext = VALUE_BITS'(char_q[3:0]);
  assign in_is_x   = (char_in_i == CHR_X);

  // Saturating multiply-accumulate by 10 or 16
  assign acc_b16  = cmd_i.main && (mode_q == MODE_HEX);
  assign acc_d    = cmd_i.main ? dig_val : 4'd0;
  assign acc_ext  = ACC_W'(value_q);
  assign acc_prod = acc_b16 ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
  assign acc_sum  = acc_prod + ACC_W'(acc_d);
  assign acc_res  = (|acc_sum[ACC_W-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                   : acc_sum[VALUE_BITS-1:0];

  // A later flush will print something
  assign flush_look = eol_q && !flushed_q &&
                      (zp_q || (mode_q == MODE_DEC) || (mode_q == MODE_HEX));

  // Printer digit selection
  assign hex_nib  = HEX_W'(num_q);
  assign cur_dig  = hex_q ? hex_nib[idx_q[HEX_IDX_W-1:0]] : bcd_q[idx_q[DEC_IDX_W-1:0]];
  assign dig_chr  = (cur_dig < 4'd10) ? (CHR_0 + {4'h0, cur_dig})
                                      : (CHR_A - 8'd10 + {4'h0, cur_dig});

  // Shift-add-3 correction of each decimal digit
  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      bcd_adj[k] = (bcd_q[k] >= 4'd5) ? (bcd_q[k] + 4'd3) : bcd_q[k];
    end
  end
  assign adj_flat = bcd_adj;

  assign out_free = !out_valid_q || !out_stall_i;

  // Status to the controller
  always_comb begin
    stat_o           = '0;
    stat_o.acc_done  = zp_q && in_is_x;
    stat_o.acc_hex   = zp_q && in_is_x && (mode_q == MODE_DEC);
    stat_o.acc_flush = zp_q && in_is_x && end_of_line_i;
    stat_o.main_num  = ((mode_q == MODE_HEX) && !is_hex) || ((mode_q == MODE_DEC) && !is_dec);
    stat_o.main_hex  = (mode_q == MODE_DEC);
    stat_o.eol       = eol_q;
    stat_o.conv_done = (conv_cnt_q == '0);
    stat_o.num_done  = (pfx_q == PFX_NONE) && (idx_q == '0);
    stat_o.char_pend = char_pend_q;
    stat_o.flush_due = eol_q && !flushed_q;
    stat_o.flush_num = zp_q || (mode_q == MODE_DEC) || (mode_q == MODE_HEX);
    stat_o.flush_hex = zp_q || (mode_q == MODE_DEC);
    stat_o.out_free  = out_free;
  end

  // Next-state logic for scan state and printer
  always_comb begin
    char_d      = char_q;
    eol_d       = eol_q;
    mode_d      = mode_q;
    zp_d        = zp_q;
    value_d     = value_q;
    char_pend_d = char_pend_q;
    flushed_d   = flushed_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    hex_d       = hex_q;
    pfx_d       = pfx_q;
    idx_d       = idx_q;
    started_d   = started_q;
    bcd_d       = bcd_q;
    conv_cnt_d  = conv_cnt_q;
    ld_hex      = 1'b0;
    ld_dec      = 1'b0;
    ld_val      = value_q;
    emit_req    = 1'b0;
    emit_chr    = char_q;
    emit_last   = 1'b0;

    // New byte: settle a held zero against it
    if (cmd_i.accept) begin
      char_d      = char_in_i;
      eol_d       = end_of_line_i;
      char_pend_d = 1'b0;
      flushed_d   = 1'b0;
      cnt_d       = '0;
      if (zp_q) begin
        zp_d = 1'b0;
        if (in_is_x) begin
          ld_hex  = (mode_q == MODE_DEC);
          mode_d  = MODE_HEX;
          value_d = '0;
        end else if (mode_q == MODE_DEC) begin
          value_d = acc_res;
        end else begin
          mode_d  = MODE_DEC;
          value_d = '0;
        end
      end
    end

    // Main classification
    if (cmd_i.main) begin
      case (mode_q)
        MODE_HEX: begin
          if (is_hex) begin
            value_d = acc_res;
          end else begin
            ld_dec  = 1'b1;
            mode_d  = MODE_TEXT;
            value_d = '0;
            if (is_zero) begin
              zp_d = 1'b1;
            end else if (is_dec) begin
              mode_d  = MODE_DEC;
              value_d = digit_ext;
            end else begin
              char_pend_d = 1'b1;
            end
          end
        end
        MODE_DEC: begin
          if (is_zero) begin
            zp_d = 1'b1;
          end else if (is_dec) begin
            value_d = acc_res;
          end else begin
            ld_hex      = 1'b1;
            mode_d      = MODE_TEXT;
            value_d     = '0;
            char_pend_d = 1'b1;
          end
        end
        default: begin
          mode_d  = MODE_TEXT;
          value_d = '0;
          if (is_zero) begin
            zp_d = 1'b1;
          end else if (is_dec) begin
            mode_d  = MODE_DEC;
            value_d = digit_ext;
          end else begin
            // plain text goes straight out and always ends the run
            emit_req  = 1'b1;
            emit_last = 1'b1;
          end
        end
      endcase
    end

    // Decimal conversion step
    if (cmd_i.conv) begin
      bcd_d      = {adj_flat[DEC_W-2:0], num_q[VALUE_BITS-1]};
      num_d      = {num_q[VALUE_BITS-2:0], 1'b0};
      conv_cnt_d = conv_cnt_q - 1'b1;
    end

    // One printer position: prefix, skipped leading zero or digit
    if (cmd_i.num) begin
      case (pfx_q)
        PFX_ZERO: begin
          emit_req = 1'b1;
          emit_chr = CHR_0;
          pfx_d    = PFX_X;
        end
        PFX_X: begin
          emit_req = 1'b1;
          emit_chr = CHR_X;
          pfx_d    = PFX_NONE;
        end
        default: begin
          if ((cur_dig != 4'd0) || started_q || (idx_q == '0)) begin
            emit_req  = 1'b1;
            emit_chr  = dig_chr;
            emit_last = (idx_q == '0) && !char_pend_q && !flush_look;
            started_d = 1'b1;
          end
          if (idx_q != '0) begin
            idx_d = idx_q - 1'b1;
          end
        end
      endcase
    end

    // Text byte held behind a number
    if (cmd_i.chr) begin
      emit_req    = 1'b1;
      emit_last   = 1'b1;
      char_pend_d = 1'b0;
    end

    // End of line: print what is open and clear the scan state
    if (cmd_i.flush) begin
      flushed_d = 1'b1;
      if (zp_q) begin
        ld_hex = 1'b1;
        ld_val = (mode_q == MODE_DEC) ? acc_res : '0;
      end else if (mode_q == MODE_DEC) begin
        ld_hex = 1'b1;
      end else if (mode_q == MODE_HEX) begin
        ld_dec = 1'b1;
      end
      mode_d  = MODE_TEXT;
      zp_d    = 1'b0;
      value_d = '0;
    end

    // Printer loads
    if (ld_hex) begin
      num_d     = ld_val;
      hex_d     = 1'b1;
      pfx_d     = PFX_ZERO;
      idx_d     = IDX_W'(HEX_DIGITS - 1);
      started_d = 1'b0;
    end
    if (ld_dec) begin
      num_d      = ld_val;
      hex_d      = 1'b0;
      pfx_d      = PFX_NONE;
      idx_d      = IDX_W'(DEC_DIGITS - 1);
      started_d  = 1'b0;
      bcd_d      = '0;
      conv_cnt_d = CONV_W'(VALUE_BITS - 1);
    end

    // Results beyond the per-byte limit are dropped
    if (emit_req && (cnt_q != CNT_W'(MAX_RESULTS))) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign emit_en = emit_req && (cnt_q != CNT_W'(MAX_RESULTS));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TEXT;
      zp_q        <= 1'b0;
      value_q     <= '0;
      char_pend_q <= 1'b0;
      flushed_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      zp_q        <= zp_d;
      value_q     <= value_d;
      char_pend_q <= char_pend_d;
      flushed_q   <= flushed_d;
      cnt_q       <= cnt_d;
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    eol_q      <= eol_d;
    num_q      <= num_d;
    hex_q      <= hex_d;
    pfx_q      <= pfx_d;
    idx_q      <= idx_d;
    started_q  <= started_d;
    bcd_q      <= bcd_d;
    conv_cnt_q <= conv_cnt_d;
    if (emit_en) begin
      out_char_q <= emit_chr;
      out_last_q <= emit_last || (cnt_q == CNT_W'(MAX_RESULTS - 1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = out_char_q;
  assign last_of_run_o = out_last_q;

endmodule

[hw/rtl/text_hex_dec_number_swapper.sv]
// Top level of the text number swapper: controller plus datapath.
// Depends on thdns_pkg, thdns_ctrl and thdns_dpath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, char_in_i,        | to block
//          | end_of_line_i                             |
//  out     | out_valid_o, out_stall_i, char_out_o,     | from block
//          | last_of_run_o                             |
//
// A text or digit byte is handled by the transfer, then one classify step.
// A hex printout emits the 0x prefix, then one character position per nibble
// (HEX_DIGITS); a decimal printout first runs the shift-add-3 converter over
// all VALUE_BITS bits, then one position per decimal digit. End of line adds
// a flush step. Input is stalled until every byte of a run is produced.
// Reset is asynchronous and active low; output stalls hold the printer.
module text_hex_dec_number_swapper #(
  parameter int HEX_DIGITS = thdns_pkg::HEX_DIGITS_DFLT,
  parameter int VALUE_BITS = thdns_pkg::VALUE_BITS_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o,
  output logic       last_of_run_o
);
  import thdns_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  thdns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  thdns_dpath #(
    .HEX_DIGITS (HEX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_in_i     (char_in_i),
    .end_of_line_i (end_of_line_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[hw/rtl/thdns_checker.sv]
// Port-level checks for the text number swapper, bound to the top level.
// Depends only on the top-level ports.
module thdns_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic       last_of_run_o
);

  // No result is offered straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // A stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(char_out_o) && $stable(last_of_run_o))
    else $error("stalled output changed");

  // While a run is unfinished no new byte may be taken
  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("input open in the middle of a run");

endmodule

bind text_hex_dec_number_swapper thdns_checker u_thdns_checker (.*);

[tb/tb_text_hex_dec_number_swapper.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the text number swapper (text_hex_dec_number_swapper).
// Uses thdns_pkg for the number format defaults. It predicts the rewritten text byte
// by byte and checks each output transfer against that prediction.
module tb_text_hex_dec_number_swapper;

  localparam int HEX_DIGITS = thdns_pkg::HEX_DIGITS_DFLT;
  localparam int VALUE_BITS = thdns_pkg::VALUE_BITS_DFLT;
  localparam int MAX_RUN    = 12;
  localparam logic [63:0] VALUE_CAP = (64'd1 << VALUE_BITS) - 64'd1;
  // decimal printout is the slowest run: converter, digits, flush, with margin
  localparam int DRAIN_CYCLES = 4 * (VALUE_BITS + HEX_DIGITS + MAX_RUN);
  localparam longint CYCLE_LIMIT = 500_000;

  typedef enum logic [1:0] {
    SCAN_TEXT = 2'd0,
    SCAN_DEC  = 2'd1,
    SCAN_HEX  = 2'd2
  } scan_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } text_out_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_in_i     = 8'h00;
  logic       end_of_line_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] char_out_o;
  logic       last_of_run_o;

  // line rewrite state of the predictor
  scan_e       scan_q    = SCAN_TEXT;
  logic        zero_held = 1'b0;
  logic [63:0] num_q     = '0;

  logic [7:0] run_q[$];
  text_out_t  expected_text_q[$];
  string      hex_glyphs  = "0123456789ABCDEF";
  string      zero_follow = "0xX5";

  bit     idle_on     = 1'b1;
  int     error_count = 0;
  longint cycle_count = 0;

  text_hex_dec_number_swapper #(
    .HEX_DIGITS(HEX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_in_i    (char_in_i),
    .end_of_line_i(end_of_line_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_out_o   (char_out_o),
    .last_of_run_o(last_of_run_o)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && idle_on && ($urandom_range(99) < 27);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic void put_char(input logic [7:0] c);
    if (run_q.size() < MAX_RUN) run_q.push_back(c);
  endfunction

  // saturating digit append
  function automatic logic [63:0] grow(input logic [63:0] v, input int unsigned base,
                                       input int unsigned digit);
    if (v > (VALUE_CAP - digit) / base) return VALUE_CAP;
    return v * base + digit;
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // 0x prefix, no leading zeros, at least one digit
  function automatic void put_hex(input logic [63:0] v);
    logic [3:0] nib;
    bit started;
    started = 1'b0;
    put_char("0");
    put_char("x");
    for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
      nib = 4'(v >> (4 * i));
      if (nib != 4'd0 || started || i == 0) begin
        started = 1'b1;
        put_char(hex_glyphs[nib]);
      end
    end
  endfunction

  function automatic void put_dec(input logic [63:0] v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'("0" + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) put_char(digs[i]);
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    int h;
    h = hex_val(c);
    // a held zero is resolved by the byte after it
    if (zero_held) begin
      zero_held = 1'b0;
      if (c == "x") begin
        if (scan_q == SCAN_DEC) put_hex(num_q);
        scan_q = SCAN_HEX;
        num_q  = '0;
        return;
      end
      if (scan_q == SCAN_DEC) begin
        num_q = grow(num_q, 10, 0);
      end else begin
        scan_q = SCAN_DEC;
        num_q  = '0;
      end
    end
    if (scan_q == SCAN_HEX) begin
      if (h >= 0) begin
        num_q = grow(num_q, 16, h);
        return;
      end
      // byte ending the literal falls through to the text-mode handling
      put_dec(num_q);
      scan_q = SCAN_TEXT;
      num_q  = '0;
    end else if (scan_q == SCAN_DEC) begin
      if (c == "0") begin
        zero_held = 1'b1;
        return;
      end
      if (c >= "1" && c <= "9") begin
        num_q = grow(num_q, 10, c - "0");
        return;
      end
      put_hex(num_q);
      scan_q = SCAN_TEXT;
      num_q  = '0;
      put_char(c);
      return;
    end
    scan_q = SCAN_TEXT;
    if (c == "0") begin
      zero_held = 1'b1;
      return;
    end
    if (c >= "1" && c <= "9") begin
      scan_q = SCAN_DEC;
      num_q  = 64'(c - "0");
      return;
    end
    put_char(c);
  endfunction

  function automatic void end_line();
    if (zero_held) begin
      if (scan_q == SCAN_DEC) begin
        num_q = grow(num_q, 10, 0);
      end else begin
        scan_q = SCAN_DEC;
        num_q  = '0;
      end
    end
    if (scan_q == SCAN_DEC) put_hex(num_q);
    else if (scan_q == SCAN_HEX) put_dec(num_q);
    scan_q    = SCAN_TEXT;
    zero_held = 1'b0;
    num_q     = '0;
  endfunction

  function automatic void predict_text(input logic [7:0] chr, input logic eol);
    run_q.delete();
    take_byte(chr);
    if (eol) end_line();
    foreach (run_q[i]) expected_text_q.push_back('{chr: run_q[i], last: (i == run_q.size() - 1)});
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin : check_text
    text_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %h last %b",
                                  char_out_o, last_of_run_o));
      end else begin
        want = expected_text_q.pop_front();
        if (char_out_o !== want.chr)
          report_mismatch($sformatf("char_out %h, expected %h", char_out_o, want.chr));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run %b, expected %b (char %h)",
                                    last_of_run_o, want.last, want.chr));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // one input transfer; returns at the accepting edge with valid still high
  task automatic send_byte(input logic [7:0] chr, input logic eol);
    while (idle_on && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    char_in_i     <= chr;
    end_of_line_i <= eol;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(chr, eol);
  endtask

  task automatic send_text(input string s, input bit eol_last);
    foreach (s[i]) send_byte(s[i], eol_last && (i == s.len() - 1));
  endtask

  // hold input until every expected byte is out, then let the block settle
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // byte extremes pass straight through
  task automatic test_text_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // decimal run cut by a hex literal, literal ended by a text byte
  task automatic test_run_boundaries();
    send_text("10x1F;", 1'b0);
  endtask

  // 0x with no digits, lower-case digit ends the literal
  task automatic test_empty_hex();
    send_text("0xa", 1'b0);
  endtask

  // held zero at end of line, decimal saturation, empty literal at end of line
  task automatic test_line_end_cases();
    send_text("0", 1'b1);
    send_text("9999999999", 1'b1);
    send_text("0x", 1'b1);
  endtask

  // random lines built from numbers, literals and text, with noise bytes
  task automatic test_random_lines(input int unsigned n_items);
    logic [7:0]  tok[$];
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    bit          eol_end;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      // middle third runs with no gaps and no stalls
      idle_on = !(sent >= n_items / 3 && sent < 2 * n_items / 3);
      if (!paused && sent >= n_items / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
      tok.delete();
      kind = $urandom_range(99);
      if (kind < 30) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (len) tok.push_back(8'("0" + $urandom_range(9)));
      end else if (kind < 55) begin
        tok.push_back("0");
        tok.push_back("x");
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 4);
        repeat (len) tok.push_back(hex_glyphs[$urandom_range(15)]);
      end else if (kind < 80) begin
        tok.push_back(8'($urandom_range(32, 126)));
      end else if (kind < 90) begin
        tok.push_back("0");
        tok.push_back(zero_follow[$urandom_range(3)]);
      end else begin
        tok.push_back(8'($urandom_range(255)));
      end
      eol_end = ($urandom_range(7) == 0);
      foreach (tok[i]) begin
        send_byte(tok[i], eol_end && (i == tok.size() - 1));
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_text_extremes();
    test_run_boundaries();
    wait_for_drain();
    test_empty_hex();
    test_line_end_cases();
    test_random_lines(450);
    wait_for_drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
